/* hdl/stps_pkg.sv */
// ---------------------------------------------------------------------------
// Spike synthesizer package
// Shared constants, item modes, register indexes and the xorshift helper function.
// ---------------------------------------------------------------------------
package stps_pkg;

   localparam int MAX_SPIKES_DEF = 1024;
   localparam int WAVE_LEN_DEF   = 64;
   localparam int SLOTS_DEF      = 8;
   localparam int PINK_ROWS_DEF  = 12;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_LD_SPK  = 2'd1,
      MODE_LD_WAVE = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_DROP_THR  = 3'd0,
      CSR_AMP_GAIN  = 3'd1,
      CSR_NOISE_SCL = 3'd2,
      CSR_EXTRA_PRB = 3'd3,
      CSR_SEED      = 3'd4,
      CSR_TMPL_LEN  = 3'd5,
      CSR_SPK_COUNT = 3'd6
   } csr_index_type;

   // One step of the 32-bit xorshift generator.
   function automatic logic [31:0] xorshift32(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

endpackage

/* hdl/stps_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module stps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/stps_slot_cell.sv */
// ---------------------------------------------------------------------------
// Spike slot cell
// Holds one playing spike; shifts to its neighbor or takes a new spike.
// ---------------------------------------------------------------------------
module stps_slot_cell #(
   parameter int PW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          shift,
   input  logic          load,
   input  logic          sh_active,
   input  logic [PW-1:0] sh_pos,
   input  logic [15:0]   sh_amp,
   input  logic [15:0]   ld_amp,
   output logic          q_active,
   output logic [PW-1:0] q_pos,
   output logic [15:0]   q_amp
);

   logic          active_ff, active_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0]   amp_ff, amp_in;

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      amp_in    = amp_ff;
      if (clear) begin
         active_in = 1'b0;
         pos_in    = '0;
         amp_in    = '0;
      end else if (shift) begin
         active_in = sh_active;
         pos_in    = sh_pos;
         amp_in    = sh_amp;
      end else if (load) begin
         active_in = 1'b1;
         pos_in    = '0;
         amp_in    = ld_amp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      pos_ff <= pos_in;
      amp_ff <= amp_in;
   end

   assign q_active = active_ff;
   assign q_pos    = pos_ff;
   assign q_amp    = amp_ff;

endmodule

/* hdl/spike_template_playback_synth_unit.sv */
// ---------------------------------------------------------------------------
// Spike template playback synthesizer
// Template and random spikes played through a ring of slot cells, plus
// scaled pink noise, summed and saturated to one sample per tick.
// ---------------------------------------------------------------------------
// A tick runs from transfer to result through two spike draws (ST_MATCH, ST_EXTRA), two pink
// noise states, the noise multiply, the ring rotation and MAC drain in ST_ROT, ST_OUT_WAIT and
// the output register. The next tick can be taken in the cycle its result is presented,
// and a tick waits in ST_OUT_WAIT while an earlier result is stalled.
// Load and restart items are taken while idle and give no result.
// Synchronous reset clears control state and counters; tables are undefined until loaded.
module spike_template_playback_synth_unit #(
   parameter int MAX_SPIKES = stps_pkg::MAX_SPIKES_DEF,
   parameter int WAVE_LEN   = stps_pkg::WAVE_LEN_DEF,
   parameter int SLOTS      = stps_pkg::SLOTS_DEF,
   parameter int PINK_ROWS  = stps_pkg::PINK_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [9:0]         req_index,
   input  logic [15:0]        req_spike_time,
   input  logic [7:0]         req_spike_amp,
   input  logic signed [15:0] req_wave_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic [31:0]        rsp_spikes_emitted,
   output logic [31:0]        rsp_spikes_dropped,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int SA     = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;
   localparam int NW     = $clog2(MAX_SPIKES + 1);
   localparam int PW     = (WAVE_LEN > 1) ? $clog2(WAVE_LEN) : 1;
   localparam int CW     = $clog2(SLOTS + 2);
   localparam int KW     = (PINK_ROWS > 1) ? $clog2(PINK_ROWS) : 1;
   localparam int PT_W   = 17 + $clog2(PINK_ROWS + 1);
   localparam int PV_W   = PT_W + 1;
   localparam int NP_W   = PV_W + 25;
   localparam int ACC_W  = 48;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MATCH, ST_EXTRA, ST_PINK1, ST_PINK2, ST_NOISE, ST_ROT, ST_OUT_WAIT
   } state_type;

   // Configuration registers.
   logic [16:0] drop_thr_ff;
   logic [11:0] amp_gain_ff;
   logic [23:0] noise_scl_ff;
   logic [31:0] extra_prb_ff;
   logic [31:0] seed_ff;
   logic [16:0] tmpl_len_ff;
   logic [10:0] spk_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_thr_ff  <= '0;
         amp_gain_ff  <= 12'd256;
         noise_scl_ff <= '0;
         extra_prb_ff <= '0;
         seed_ff      <= 32'd1;
         tmpl_len_ff  <= 17'h10000;
         spk_count_ff <= '0;
      end else if (csr_we) begin
         unique case (stps_pkg::csr_index_type'(csr_index))
            stps_pkg::CSR_DROP_THR:  drop_thr_ff  <= csr_wdata[16:0];
            stps_pkg::CSR_AMP_GAIN:  amp_gain_ff  <= csr_wdata[11:0];
            stps_pkg::CSR_NOISE_SCL: noise_scl_ff <= csr_wdata[23:0];
            stps_pkg::CSR_EXTRA_PRB: extra_prb_ff <= csr_wdata;
            stps_pkg::CSR_SEED:      seed_ff      <= csr_wdata;
            stps_pkg::CSR_TMPL_LEN:  tmpl_len_ff  <= csr_wdata[16:0];
            stps_pkg::CSR_SPK_COUNT: spk_count_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // Control and datapath state.
   state_type                state_ff, state_in;
   logic [31:0]              rnd_ff, rnd_in;
   logic [15:0]              pos_ff, pos_in;
   logic [NW-1:0]            nsi_ff, nsi_in;
   logic [PINK_ROWS-1:0]     pcnt_ff, pcnt_in;
   logic signed [PT_W-1:0]   ptot_ff, ptot_in;
   logic signed [PV_W-1:0]   pval_ff, pval_in;
   logic signed [15:0]       rows_ff [PINK_ROWS];
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [31:0]              emit_ff, emit_in;
   logic [31:0]              drop_ff, drop_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]       sample_ff, sample_in;
   logic [31:0]              out_em_ff, out_em_in;
   logic [31:0]              out_dr_ff, out_dr_in;
   logic                     p1_vld_ff;
   logic [15:0]              p1_amp_ff;
   logic                     prod_vld_ff;
   logic signed [32:0]       prod_ff;

   logic                     row_we, rows_clear, cells_clear, shift, ins_req;
   logic [KW-1:0]            row_k;
   logic signed [15:0]       row_val;
   logic [15:0]              ins_amp;
   logic [31:0]              rnd_next;
   logic                     req_xfer;

   // Tables.
   logic [23:0]              spk_rd;
   logic [15:0]              wave_rd;
   logic                     spk_we, wave_we;

   // Slot ring.
   logic                     cell_act [SLOTS];
   logic [PW-1:0]            cell_pos [SLOTS];
   logic [15:0]              cell_amp [SLOTS];
   logic [SLOTS-1:0]         free_oh;
   logic                     free_found;
   logic [PW:0]              head_inc;
   logic                     tail_act;
   logic [PW-1:0]            tail_pos;

   assign req_xfer = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rnd_next = stps_pkg::xorshift32(rnd_ff);

   assign spk_we  = req_xfer && (req_mode == stps_pkg::MODE_LD_SPK)
                    && (32'(req_index) < MAX_SPIKES);
   assign wave_we = req_xfer && (req_mode == stps_pkg::MODE_LD_WAVE)
                    && (32'(req_index) < WAVE_LEN);

   stps_ram #(.WIDTH(24), .DEPTH(MAX_SPIKES), .AW(SA)) u_spk_ram (
      .clock   (clock),
      .wr_en   (spk_we),
      .wr_addr (SA'(req_index)),
      .wr_data ({req_spike_time, req_spike_amp}),
      .rd_addr (SA'(nsi_ff)),
      .rd_data (spk_rd)
   );

   stps_ram #(.WIDTH(16), .DEPTH(WAVE_LEN), .AW(PW)) u_wave_ram (
      .clock   (clock),
      .wr_en   (wave_we),
      .wr_addr (PW'(req_index)),
      .wr_data (req_wave_value),
      .rd_addr (cell_pos[0]),
      .rd_data (wave_rd)
   );

   // The head cell advances as it wraps round to the tail.
   assign head_inc = {1'b0, cell_pos[0]} + (PW+1)'(1);
   assign tail_act = cell_act[0] && (32'(head_inc) < WAVE_LEN);
   assign tail_pos = head_inc[PW-1:0];

   always_comb begin
      free_oh    = '0;
      free_found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!cell_act[i] && !free_found) begin
            free_oh[i] = 1'b1;
            free_found = 1'b1;
         end
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      stps_slot_cell #(.PW(PW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (cells_clear),
         .shift     (shift),
         .load      (ins_req && free_oh[g]),
         .sh_active ((g == SLOTS - 1) ? tail_act : cell_act[(g + 1) % SLOTS]),
         .sh_pos    ((g == SLOTS - 1) ? tail_pos : cell_pos[(g + 1) % SLOTS]),
         .sh_amp    (cell_amp[(g + 1) % SLOTS]),
         .ld_amp    (ins_amp),
         .q_active  (cell_act[g]),
         .q_pos     (cell_pos[g]),
         .q_amp     (cell_amp[g])
      );
   end

   always_comb begin
      logic                   match;
      logic [31:0]            limit;
      logic [19:0]            amp_prod;
      logic [PINK_ROWS-1:0]   pc_new;
      logic                   k_found;
      logic signed [PT_W-1:0] nv_ext;
      logic signed [PT_W-1:0] old_ext;
      logic signed [15:0]     draw16;
      logic signed [NP_W-1:0] noise_prod;
      logic [16:0]            npos;

      state_in     = state_ff;
      rnd_in       = rnd_ff;
      pos_in       = pos_ff;
      nsi_in       = nsi_ff;
      pcnt_in      = pcnt_ff;
      ptot_in      = ptot_ff;
      pval_in      = pval_ff;
      acc_in       = acc_ff;
      emit_in      = emit_ff;
      drop_in      = drop_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      out_em_in    = out_em_ff;
      out_dr_in    = out_dr_ff;
      row_we       = 1'b0;
      row_k        = '0;
      row_val      = '0;
      rows_clear   = 1'b0;
      cells_clear  = 1'b0;
      shift        = 1'b0;
      ins_req      = 1'b0;
      ins_amp      = '0;
      k_found      = 1'b0;
      draw16       = signed'(rnd_next[15:0]);
      nv_ext       = PT_W'(draw16);
      old_ext      = '0;
      pc_new       = pcnt_ff + PINK_ROWS'(1);
      limit        = (32'(spk_count_ff) < MAX_SPIKES) ? 32'(spk_count_ff)
                                                       : 32'(MAX_SPIKES);
      match        = (32'(nsi_ff) < limit) && (pos_ff == spk_rd[23:8]);
      amp_prod     = spk_rd[7:0] * amp_gain_ff;
      noise_prod   = NP_W'(pval_ff) * NP_W'(signed'({1'b0, noise_scl_ff}));
      npos         = {1'b0, pos_ff} + 17'd1;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff >>> 7);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (stps_pkg::mode_type'(req_mode))
                  stps_pkg::MODE_TICK: state_in = ST_MATCH;
                  stps_pkg::MODE_RESTART: begin
                     rnd_in      = (seed_ff != 32'd0) ? seed_ff : 32'd1;
                     pos_in      = '0;
                     nsi_in      = '0;
                     pcnt_in     = '0;
                     ptot_in     = '0;
                     rows_clear  = 1'b1;
                     cells_clear = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_MATCH: begin
            if (match) begin
               nsi_in = nsi_ff + NW'(1);
               rnd_in = rnd_next;
               if ({1'b0, rnd_next[15:0]} < drop_thr_ff) begin
                  drop_in = drop_ff + 32'd1;
               end else begin
                  ins_req = 1'b1;
                  ins_amp = 16'(amp_prod[19:8]);
               end
            end
            state_in = ST_EXTRA;
         end
         ST_EXTRA: begin
            if (extra_prb_ff != 32'd0) begin
               rnd_in = rnd_next;
               if (rnd_next < extra_prb_ff) begin
                  ins_req = 1'b1;
                  ins_amp = 16'(amp_gain_ff[11:1]);
               end
            end
            state_in = ST_PINK1;
         end
         ST_PINK1: begin
            pcnt_in = pc_new;
            for (int i = 0; i < PINK_ROWS; i++) begin
               if (pc_new[i] && !k_found) begin
                  row_k   = KW'(i);
                  k_found = 1'b1;
               end
            end
            if (k_found) begin
               rnd_in  = rnd_next;
               old_ext = PT_W'(rows_ff[row_k]);
               ptot_in = ptot_ff + nv_ext - old_ext;
               row_we  = 1'b1;
               row_val = draw16;
            end
            state_in = ST_PINK2;
         end
         ST_PINK2: begin
            rnd_in   = rnd_next;
            pval_in  = PV_W'(ptot_ff) + PV_W'(draw16);
            state_in = ST_NOISE;
         end
         ST_NOISE: begin
            acc_in   = ACC_W'(noise_prod >>> 16);
            cnt_in   = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            // Rotation steps first, then the MAC pipe (p1 and prod registers) drains.
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff < CW'(SLOTS)) begin
               shift = 1'b1;
            end
            if (cnt_ff == CW'(SLOTS + 1)) begin
               state_in = ST_OUT_WAIT;
            end
         end
         ST_OUT_WAIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (acc_ff > SAT_HI) begin
                  sample_in = 16'sh7FFF;
               end else if (acc_ff < SAT_LO) begin
                  sample_in = -16'sh8000;
               end else begin
                  sample_in = acc_ff[15:0];
               end
               out_em_in = emit_ff;
               out_dr_in = drop_ff;
               if ((npos >= tmpl_len_ff) || npos[16]) begin
                  pos_in = '0;
                  nsi_in = '0;
               end else begin
                  pos_in = npos[15:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (ins_req && free_found) begin
         emit_in = emit_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= 32'd1;
         pos_ff       <= '0;
         nsi_ff       <= '0;
         pcnt_ff      <= '0;
         ptot_ff      <= '0;
         emit_ff      <= '0;
         drop_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         p1_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         for (int i = 0; i < PINK_ROWS; i++) begin
            rows_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         pos_ff       <= pos_in;
         nsi_ff       <= nsi_in;
         pcnt_ff      <= pcnt_in;
         ptot_ff      <= ptot_in;
         emit_ff      <= emit_in;
         drop_ff      <= drop_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_vld_ff    <= shift && cell_act[0];
         prod_vld_ff  <= p1_vld_ff;
         if (rows_clear) begin
            for (int i = 0; i < PINK_ROWS; i++) begin
               rows_ff[i] <= '0;
            end
         end else if (row_we) begin
            rows_ff[row_k] <= row_val;
         end
      end
      pval_ff   <= pval_in;
      acc_ff    <= acc_in;
      sample_ff <= sample_in;
      out_em_ff <= out_em_in;
      out_dr_ff <= out_dr_in;
      p1_amp_ff <= cell_amp[0];
      prod_ff   <= 33'(signed'(wave_rd)) * 33'(signed'({1'b0, p1_amp_ff}));
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = sample_ff;
   assign rsp_spikes_emitted = out_em_ff;
   assign rsp_spikes_dropped = out_dr_ff;

   // A restart leaves the template position and pink counter at zero.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_mode == stps_pkg::MODE_RESTART))
      |=> (pos_ff == 16'd0) && (pcnt_ff == '0))
      else $error("restart did not clear position state");

   // At most one spike starts in any cycle.
   a_emit_step: assert property (@(posedge clock) disable iff (reset)
      (emit_ff == $past(emit_ff)) || (emit_ff == $past(emit_ff) + 32'd1))
      else $error("emitted counter jumped");

   // The MAC pipe is empty whenever a new tick begins.
   a_mac_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !p1_vld_ff && !prod_vld_ff)
      else $error("slot accumulation still in flight at idle");

endmodule

/* verif/spike_template_playback_synth_unit_tb.sv */
// ---------------------------------------------------------------------------
// Spike synthesizer testbench
// Drives ticks, table loads and restarts through the request channel and
// checks every sample and spike counter against a cycle-free predictor.
// ---------------------------------------------------------------------------
module spike_template_playback_synth_unit_tb;

   localparam int MAXSP = 1024;
   localparam int WLEN  = 64;
   localparam int NSLOT = 8;
   localparam int PROWS = 12;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_mode;
   logic [9:0]         req_index;
   logic [15:0]        req_spike_time;
   logic [7:0]         req_spike_amp;
   logic signed [15:0] req_wave_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_sample;
   logic [31:0]        rsp_spikes_emitted;
   logic [31:0]        rsp_spikes_dropped;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   spike_template_playback_synth_unit u_top (.*);

   typedef struct packed {
      logic signed [15:0] sample;
      logic [31:0]        emitted;
      logic [31:0]        dropped;
   } tick_result_type;

   // Predictor state.
   logic [16:0] drop_thr;
   logic [11:0] gain;
   logic [23:0] nscale;
   logic [31:0] extra_prb;
   logic [31:0] seed_reg;
   logic [16:0] tmpl_len;
   logic [10:0] spk_cnt;
   logic [31:0] rng;
   logic [15:0] pos;
   logic [10:0] next_idx;
   logic        s_act [NSLOT];
   logic [6:0]  s_pos [NSLOT];
   logic [15:0] s_amp [NSLOT];
   int          pink_row [PROWS];
   int          pink_sum;
   logic [11:0] pink_cnt;
   logic [15:0] t_time [MAXSP];
   logic [7:0]  t_amp [MAXSP];
   logic signed [15:0] w_tab [WLEN];
   logic [31:0] n_emit, n_drop;

   tick_result_type expected_samples[$];
   int  errors;
   int  burst_left;
   logic [31:0] stall_pat;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [31:0] next_rand();
      logic [31:0] x;
      x = rng;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      rng = x;
      return x;
   endfunction

   function automatic int to_s16(logic [31:0] v);
      return int'($signed(v[15:0]));
   endfunction

   function automatic longint fshift(longint x, int k);
      return x >>> k;
   endfunction

   task automatic claim_slot(logic [31:0] a);
      for (int i = 0; i < NSLOT; i++) begin
         if (!s_act[i]) begin
            s_act[i] = 1'b1;
            s_pos[i] = '0;
            s_amp[i] = (a > 32'hFFFF) ? 16'hFFFF : a[15:0];
            n_emit++;
            return;
         end
      end
   endtask

   task automatic clear_playback();
      rng = (seed_reg != 0) ? seed_reg : 32'd1;
      pos = '0;
      next_idx = '0;
      for (int i = 0; i < NSLOT; i++) begin
         s_act[i] = 1'b0; s_pos[i] = '0; s_amp[i] = '0;
      end
      for (int i = 0; i < PROWS; i++) pink_row[i] = 0;
      pink_sum = 0;
      pink_cnt = '0;
   endtask

   task automatic predict_tick();
      longint acc;
      int lim, k, nv, pn;
      logic [31:0] npos;
      tick_result_type r;
      acc = 0;
      lim = (spk_cnt < MAXSP) ? spk_cnt : MAXSP;
      if (next_idx < lim && pos == t_time[next_idx]) begin
         logic [31:0] base;
         base = t_amp[next_idx];
         next_idx++;
         if ({15'd0, next_rand() & 32'hFFFF} < {15'd0, 15'd0, drop_thr}) n_drop++;
         else claim_slot((base * gain) >> 8);
      end
      if (extra_prb != 0 && next_rand() < extra_prb) claim_slot((32'd128 * gain) >> 8);
      for (int i = 0; i < NSLOT; i++) begin
         if (s_act[i]) begin
            acc += fshift(longint'(w_tab[s_pos[i]]) * longint'(s_amp[i]), 7);
            s_pos[i]++;
            if (s_pos[i] >= WLEN) s_act[i] = 1'b0;
         end
      end
      pink_cnt = pink_cnt + 1;
      k = 0;
      while (k < PROWS && pink_cnt[k] == 1'b0) k++;
      if (k < PROWS) begin
         nv = to_s16(next_rand());
         pink_sum += nv - pink_row[k];
         pink_row[k] = nv;
      end
      pn = pink_sum + to_s16(next_rand());
      acc += fshift(longint'(pn) * longint'(nscale), 16);
      npos = pos + 1;
      if (npos >= tmpl_len || npos > 32'hFFFF) begin
         pos = '0; next_idx = '0;
      end else begin
         pos = npos[15:0];
      end
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      r.sample = acc[15:0];
      r.emitted = n_emit;
      r.dropped = n_drop;
      expected_samples.push_back(r);
   endtask

   // Sends one item with bursty gaps, then updates the predictor.
   task automatic send_item(stps_pkg::mode_type m, logic [9:0] idx, logic [15:0] st,
                            logic [7:0] sa, logic [15:0] wv);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= m;
      req_index <= idx;
      req_spike_time <= st;
      req_spike_amp <= sa;
      req_wave_value <= wv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (m)
         stps_pkg::MODE_LD_SPK: begin
            t_time[idx] = st; t_amp[idx] = sa;
         end
         stps_pkg::MODE_LD_WAVE: if (idx < WLEN) begin
            w_tab[idx] = wv;
         end
         stps_pkg::MODE_RESTART: clear_playback();
         default: predict_tick();
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(stps_pkg::csr_index_type r, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (r)
         stps_pkg::CSR_DROP_THR:  drop_thr = v[16:0];
         stps_pkg::CSR_AMP_GAIN:  gain = v[11:0];
         stps_pkg::CSR_NOISE_SCL: nscale = v[23:0];
         stps_pkg::CSR_EXTRA_PRB: extra_prb = v;
         stps_pkg::CSR_SEED:      seed_reg = v;
         stps_pkg::CSR_TMPL_LEN:  tmpl_len = v[16:0];
         default:                 spk_cnt = v[10:0];
      endcase
   endtask

   task automatic tick();
      send_item(stps_pkg::MODE_TICK, 10'($urandom), 16'($urandom), 8'($urandom),
                16'($urandom));
   endtask

   // Fills the whole wave table, with both extremes in the first two entries.
   task automatic load_waves();
      for (int i = 0; i < WLEN; i++)
         send_item(stps_pkg::MODE_LD_WAVE, 10'(i), 16'($urandom), 8'($urandom),
                   i == 0 ? 16'h7FFF : i == 1 ? 16'h8000 : 16'($urandom));
   endtask

   // Sorted spike table of n entries over a template of length len.
   task automatic load_spikes(int n, int len, bit extreme_amp);
      int t;
      t = 0;
      for (int i = 0; i < n; i++) begin
         t += $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2 * len / (n + 1) + 1);
         if (t > len - 1) t = len - 1;
         send_item(stps_pkg::MODE_LD_SPK, 10'(i), 16'(t),
                   extreme_amp ? 8'((i % 2) ? 255 : 0) : 8'($urandom), 16'($urandom));
      end
   endtask

   task automatic test_directed();
      load_waves();
      // Out-of-range wave index is ignored.
      send_item(stps_pkg::MODE_LD_WAVE, 10'd1023, 16'd0, 8'd0, 16'h1234);
      send_item(stps_pkg::MODE_LD_SPK, 10'd1023, 16'hFFFF, 8'hFF, 16'd0);
      send_item(stps_pkg::MODE_LD_SPK, 10'd0, 16'd0, 8'd255, 16'd0);
      send_item(stps_pkg::MODE_LD_SPK, 10'd1, 16'd1, 8'd128, 16'd0);
      send_item(stps_pkg::MODE_LD_SPK, 10'd2, 16'd2, 8'd0, 16'd0);
      drain();
      write_reg(stps_pkg::CSR_SPK_COUNT, 32'd3);
      write_reg(stps_pkg::CSR_AMP_GAIN, 32'd2048);
      write_reg(stps_pkg::CSR_TMPL_LEN, 32'd5);
      write_reg(stps_pkg::CSR_NOISE_SCL, 32'hFFFFFF);
      repeat (12) tick();
      send_item(stps_pkg::MODE_RESTART, 10'd0, 16'd0, 8'd0, 16'd0);
      repeat (4) tick();
   endtask

   task automatic test_drop_and_extra();
      drain();
      write_reg(stps_pkg::CSR_DROP_THR, 32'd65536);
      write_reg(stps_pkg::CSR_EXTRA_PRB, 32'h8000_0000);
      write_reg(stps_pkg::CSR_SEED, 32'd0);
      write_reg(stps_pkg::CSR_NOISE_SCL, 32'd0);
      send_item(stps_pkg::MODE_RESTART, 10'd0, 16'd0, 8'd0, 16'd0);
      // Extra spikes fill every slot, so some are lost.
      repeat (50) tick();
      drain();
      write_reg(stps_pkg::CSR_DROP_THR, 32'd30000);
      write_reg(stps_pkg::CSR_EXTRA_PRB, 32'd1);
      write_reg(stps_pkg::CSR_AMP_GAIN, 32'd0);
      repeat (30) tick();
   endtask

   task automatic test_random_phases();
      int len, n;
      for (int ph = 0; ph < 10; ph++) begin
         drain();
         len = ph == 9 ? 0 : ($urandom_range(0, 3) == 0 ? 65536 : $urandom_range(1, 200));
         n = (ph == 4) ? 1024 : $urandom_range(0, 16);
         write_reg(stps_pkg::CSR_TMPL_LEN, ph == 8 ? 32'h1FFFF : 32'(len));
         write_reg(stps_pkg::CSR_SEED, $urandom);
         write_reg(stps_pkg::CSR_DROP_THR,
                   $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(0, 65536));
         write_reg(stps_pkg::CSR_AMP_GAIN, $urandom_range(0, 4095));
         write_reg(stps_pkg::CSR_NOISE_SCL,
                   $urandom_range(0, 1) ? $urandom_range(0, 200000) : $urandom);
         write_reg(stps_pkg::CSR_EXTRA_PRB,
                   $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 32'h2000_0000));
         write_reg(stps_pkg::CSR_SPK_COUNT, ph == 4 ? 32'd2047 : 32'(n));
         load_spikes(n, (len == 0 || len > 65536) ? 65536 : len, ph == 1);
         if (ph == 2) load_waves();
         send_item(stps_pkg::MODE_RESTART, 10'd0, 16'd0, 8'd0, 16'd0);
         for (int i = 0; i < 15; i++) begin
            case ($urandom_range(0, 29))
               0: send_item(stps_pkg::MODE_RESTART, 10'($urandom), 16'($urandom),
                            8'($urandom), 16'($urandom));
               1: send_item(stps_pkg::MODE_LD_WAVE, 10'($urandom), 16'($urandom),
                            8'($urandom), 16'($urandom));
               default: tick();
            endcase
         end
      end
   endtask

   // Receiver stalls follow a rotating random pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_pat <= $urandom;
      end else begin
         stall_pat <= {stall_pat[30:0], stall_pat[31]} ^ ($urandom_range(0, 63) == 0 ? $urandom : 0);
         rsp_stall <= stall_pat[0] & stall_pat[3];
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected result sample=%0d", $time, rsp_sample);
            errors++;
         end else begin
            tick_result_type e;
            e = expected_samples.pop_front();
            if (rsp_sample !== e.sample) begin
               $display("%0t: sample expected %0d actual %0d", $time, e.sample, rsp_sample);
               errors++;
            end
            if (rsp_spikes_emitted !== e.emitted) begin
               $display("%0t: emitted expected %0d actual %0d", $time, e.emitted,
                        rsp_spikes_emitted);
               errors++;
            end
            if (rsp_spikes_dropped !== e.dropped) begin
               $display("%0t: dropped expected %0d actual %0d", $time, e.dropped,
                        rsp_spikes_dropped);
               errors++;
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      errors = 0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = stps_pkg::MODE_TICK;
      req_index = '0;
      req_spike_time = '0;
      req_spike_amp = '0;
      req_wave_value = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      drop_thr = '0; gain = 12'd256; nscale = '0; extra_prb = '0;
      seed_reg = 32'd1; tmpl_len = 17'h10000; spk_cnt = '0;
      n_emit = '0; n_drop = '0;
      clear_playback();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drop_and_extra();
      test_random_phases();
      drain();
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/stps_pkg.sv
hdl/stps_ram.sv
hdl/stps_slot_cell.sv
hdl/spike_template_playback_synth_unit.sv
verif/spike_template_playback_synth_unit_tb.sv
